// ----- src/spq_pkg.sv -----
// shared types, constants and rank compare for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
package spq_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned KEY_W   = 64;

  localparam logic [LEVEL_W-1:0] MOTHER        = 3'd1;
  localparam logic [LEVEL_W-1:0] ADVERTISEMENT = 3'd6;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_READOUT = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // shift command broadcast along the chain
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

  // stored entry a ranks at or ahead of b (ties stay ahead)
  function automatic logic ranks_le(entry_t a, entry_t b);
    logic res;
    if (a.level != b.level) begin
      res = (a.level < b.level);
    end else begin
      res = (a.key <= b.key);
    end
    return res;
  endfunction

  function automatic logic [LEVEL_W-1:0] clamp_level(logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] res;
    res = lvl;
    if (lvl < MOTHER) begin
      res = MOTHER;
    end
    if (lvl > ADVERTISEMENT) begin
      res = ADVERTISEMENT;
    end
    return res;
  endfunction

endpackage

// ----- src/spq_cell.sv -----
// one slot of the sorted chain: keeps, takes the new entry or takes its neighbor
// depends on spq_pkg
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  spq_pkg::entry_t     new_i,
  input  spq_pkg::entry_t     prev_i,
  input  logic                prev_keep_i,
  input  spq_pkg::entry_t     next_i,
  input  logic                next_occ_i,
  input  spq_pkg::entry_t     head_i,
  output spq_pkg::entry_t     entry_o,
  output logic                keep_o
);

  spq_pkg::entry_t entry_q, entry_d;

  assign keep_o  = occ_i && spq_pkg::ranks_le(entry_q, new_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        // boundary cell takes the new entry, the rest shift down by one
        entry_d = prev_keep_i ? new_i : prev_i;
      end
    end else if (ctrl_i.rotate) begin
      // rotate the occupied part toward the head
      entry_d = next_occ_i ? next_i : head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- src/sorted_priority_queue.sv -----
// sorted priority queue: an insert's status transaction is registered at the accepting
// edge, so inserts run one per cycle while the output drains; readout of n entries holds
// the input off until the last is registered: the first is registered in the cycle after
// acceptance, then one per cycle by rotating the chain while the output is not stalled;
// an empty readout gives only a marker; a stalled output register holds the input off;
// reset (async, active low) empties the queue and output register; slot payload is not reset
module sorted_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [spq_pkg::LEVEL_W-1:0]   level_i,
  input  logic [spq_pkg::KEY_W-1:0]     name_key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          entry_valid_o,
  output logic [spq_pkg::LEVEL_W-1:0]   out_level_o,
  output logic [spq_pkg::KEY_W-1:0]     out_name_key_o,
  output logic                          overflow_o,
  output logic                          last_o
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                     state_q;
  logic [spq_pkg::CNT_W-1:0]  cnt_q;
  logic [spq_pkg::CNT_W-1:0]  rem_q;

  logic                       out_valid_q;
  logic                       entry_valid_q;
  logic                       overflow_q;
  logic                       last_q;
  spq_pkg::entry_t            out_q;

  logic                       out_free;
  logic                       in_acc;
  logic                       full;
  spq_pkg::entry_t            new_entry;
  spq_pkg::cell_ctrl_t        ctrl;

  spq_pkg::entry_t            cell_entry [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]  cell_keep;
  logic [spq_pkg::DEPTH-1:0]  cell_occ;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));

  assign new_entry.level = spq_pkg::clamp_level(level_i);
  assign new_entry.key   = name_key_i;

  assign ctrl.insert = in_acc && (action_i == spq_pkg::ACT_INSERT);
  assign ctrl.rotate = (state_q == ST_READ) && out_free;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t prev_e;
    spq_pkg::entry_t next_e;
    logic            prev_k;
    logic            next_o;

    assign cell_occ[i] = (cnt_q > spq_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign prev_e = new_entry;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_k = cell_keep[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_last
      assign next_e = cell_entry[0];
      assign next_o = 1'b0;
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
      assign next_o = cell_occ[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (cell_occ[i]),
      .new_i      (new_entry),
      .prev_i     (prev_e),
      .prev_keep_i(prev_k),
      .next_i     (next_e),
      .next_occ_i (next_o),
      .head_i     (cell_entry[0]),
      .entry_o    (cell_entry[i]),
      .keep_o     (cell_keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      rem_q         <= '0;
      out_valid_q   <= 1'b0;
      entry_valid_q <= 1'b0;
      overflow_q    <= 1'b0;
      last_q        <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            out_valid_q <= 1'b1;
            last_q      <= 1'b1;
            if (action_i == spq_pkg::ACT_INSERT) begin
              entry_valid_q <= 1'b1;
              overflow_q    <= full;
              out_q         <= new_entry;
              if (!full) begin
                cnt_q <= cnt_q + spq_pkg::CNT_W'(1);
              end
            end else if (cnt_q == '0) begin
              // empty readout gives a single marker transaction
              entry_valid_q <= 1'b0;
              overflow_q    <= 1'b0;
              out_q         <= '0;
            end else begin
              out_valid_q <= 1'b0;
              rem_q       <= cnt_q;
              state_q     <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            entry_valid_q <= 1'b1;
            overflow_q    <= 1'b0;
            out_q         <= cell_entry[0];
            last_q        <= (rem_q == spq_pkg::CNT_W'(1));
            rem_q         <= rem_q - spq_pkg::CNT_W'(1);
            if (rem_q == spq_pkg::CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entry_valid_o  = entry_valid_q;
  assign out_level_o    = out_q.level;
  assign out_name_key_o = out_q.key;
  assign overflow_o     = overflow_q;
  assign last_o         = last_q;

endmodule
